### rtl/gup_pkg.sv
// gup_pkg: shared types, register codes and helpers for the gravity up vector core
// no dependencies, imported by gravity_up_vector_core and tb_top
package gup_pkg;

  // register file layout
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 5;
  localparam logic [2:0] RegForceX    = 3'd0;
  localparam logic [2:0] RegForceY    = 3'd1;
  localparam logic [2:0] RegForceZ    = 3'd2;
  localparam logic [2:0] RegCenter    = 3'd3;
  localparam logic [2:0] RegAccelEn   = 3'd4;
  localparam logic [2:0] RegAccelGain = 3'd5;

  // reset values
  localparam logic [31:0] ForceYReset = 32'h0001_0000;

  // normalization datapath
  localparam int unsigned MagW      = 30;
  localparam int unsigned TargetMsb = 29;
  localparam int unsigned RootW     = 31;
  localparam int unsigned QuotW     = 17;
  localparam int unsigned NumW      = 48;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = QuotW;

  // side data carried along the normalization pipe
  typedef struct packed {
    logic [2:0][31:0] fr;
    logic [2:0][63:0] prod;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [2:0][MagW-1:0] m;
    logic [2:0]        sgn;
    logic              zero;
  } nrm_t;

  // position of the highest set bit
  function automatic logic [5:0] msb_pos(input logic [32:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // saturate a 65 bit signed value to 32 bits signed
  function automatic logic [31:0] sat32(input logic [64:0] v);
    logic [31:0] r;
    if ((&v[64:31]) || !(|v[64:31])) r = v[31:0];
    else if (v[64]) r = 32'h8000_0000;
    else r = 32'h7FFF_FFFF;
    return r;
  endfunction

endpackage

### rtl/gravity_up_vector_core.sv
// gravity_up_vector_core: up vector from a gravity model, orthogonalized against front
// depends on gup_pkg for register codes, pipe types and saturation helpers
//
// usage
//   input channel carries position, front and acceleration (Q16.16), one transaction
//   per cycle when in_ready_o is high; output channel carries up_x/y/z (Q16.16)
//   configuration through the APB-style port, register i at byte address 4*i;
//   write it only while the core is idle
//   latency: 62 cycles from input transaction to output valid with no stall
//   throughput: one item per cycle, set by the fully pipelined datapath: a
//   61 stage pipe (magnitude scaling, 32 square root stages of one bit each,
//   17 restoring division stages, two cross products with split multipliers)
//   a two entry output buffer follows the pipe; in_ready_o drops only while
//   that buffer is full, then the whole pipe holds and nothing is lost
//   reset clears all valid bits, empties the output buffer and loads the
//   register reset values (force = (0, 1.0, 0), modes off, gain 0)
module gravity_up_vector_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gup_pkg::AddrW-1:0] paddr,
  input  logic [gup_pkg::DataW-1:0] pwdata,
  output logic [gup_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [31:0]        pos_z_i,
  input  logic signed [31:0]        front_x_i,
  input  logic signed [31:0]        front_y_i,
  input  logic signed [31:0]        front_z_i,
  input  logic signed [31:0]        accel_x_i,
  input  logic signed [31:0]        accel_y_i,
  input  logic signed [31:0]        accel_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [31:0]        up_x_o,
  output logic signed [31:0]        up_y_o,
  output logic signed [31:0]        up_z_o
);
  import gup_pkg::*;

  // configuration registers
  logic signed [31:0] force_q [3];
  logic               center_q, accen_q;
  logic signed [31:0] gain_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q[0] <= '0;
      force_q[1] <= ForceYReset;
      force_q[2] <= '0;
      center_q   <= 1'b0;
      accen_q    <= 1'b0;
      gain_q     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegForceX:    force_q[0] <= pwdata;
        RegForceY:    force_q[1] <= pwdata;
        RegForceZ:    force_q[2] <= pwdata;
        RegCenter:    center_q   <= pwdata[0];
        RegAccelEn:   accen_q    <= pwdata[0];
        RegAccelGain: gain_q     <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      RegForceX:    prdata = force_q[0];
      RegForceY:    prdata = force_q[1];
      RegForceZ:    prdata = force_q[2];
      RegCenter:    prdata = {31'b0, center_q};
      RegAccelEn:   prdata = {31'b0, accen_q};
      RegAccelGain: prdata = gain_q;
      default:      prdata = '0;
    endcase
  end

  // pipe enable from the output buffer fill
  logic [1:0] ob_cnt_q;
  logic       en;
  assign en         = (ob_cnt_q != 2'd2);
  assign in_ready_o = en;

  // input gathering
  logic signed [31:0] pos [3], fr_in [3], ac_in [3];
  assign pos[0] = pos_x_i;   assign pos[1] = pos_y_i;   assign pos[2] = pos_z_i;
  assign fr_in[0] = front_x_i; assign fr_in[1] = front_y_i; assign fr_in[2] = front_z_i;
  assign ac_in[0] = accel_x_i; assign ac_in[1] = accel_y_i; assign ac_in[2] = accel_z_i;

  // stage 1: center difference magnitudes, acceleration product
  logic        s1_v_q;
  logic [32:0] s1_m_q [3];
  logic [2:0]  s1_sgn_q;
  side_t       s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    logic signed [32:0] dif;
    logic signed [63:0] pr;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dif = {pos[i][31], pos[i]} - {force_q[i][31], force_q[i]};
        pr  = ac_in[i] * gain_q;
        s1_m_q[i]         <= dif[32] ? 33'(-dif) : 33'(dif);
        s1_sgn_q[i]       <= dif[32];
        s1_side_q.fr[i]   <= fr_in[i];
        s1_side_q.prod[i] <= pr;
      end
    end
  end

  // stage 2: leading one of the largest magnitude
  logic        s2_v_q;
  logic [32:0] s2_m_q [3];
  logic [2:0]  s2_sgn_q;
  side_t       s2_side_q;
  logic        s2_zero_q;
  logic [1:0]  s2_rsh_q;
  logic [4:0]  s2_lsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] orv;
    logic [5:0]  p;
    if (en) begin
      orv = s1_m_q[0] | s1_m_q[1] | s1_m_q[2];
      p   = msb_pos(orv);
      s2_m_q    <= s1_m_q;
      s2_sgn_q  <= s1_sgn_q;
      s2_side_q <= s1_side_q;
      s2_zero_q <= (orv == '0);
      s2_rsh_q  <= (p > 6'(TargetMsb)) ? 2'(p - 6'(TargetMsb)) : 2'd0;
      s2_lsh_q  <= (p < 6'(TargetMsb)) ? 5'(6'(TargetMsb) - p) : 5'd0;
    end
  end

  // stage 3: scale magnitudes so the largest lies in [2^29, 2^30), unless all are zero
  logic  s3_v_q;
  nrm_t  s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] t;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t = (s2_m_q[i] >> s2_rsh_q) << s2_lsh_q;
        s3_q.m[i] <= t[MagW-1:0];
      end
      s3_q.sgn  <= s2_sgn_q;
      s3_q.side <= s2_side_q;
      s3_q.zero <= s2_zero_q;
    end
  end

  // stage 4: squares
  logic        s4_v_q;
  nrm_t        s4_q;
  logic [59:0] s4_sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q <= s3_q;
      for (int i = 0; i < 3; i++) begin
        s4_sq_q[i] <= 60'(s3_q.m[i]) * 60'(s3_q.m[i]);
      end
    end
  end

  // square root pipe, one result bit per stage
  logic        sq_v_q   [SqrtSteps+1];
  nrm_t        sq_q     [SqrtSteps+1];
  logic [63:0] sq_s_q   [SqrtSteps+1];
  logic [63:0] sq_res_q [SqrtSteps+1];

  // stage 5: sum of squares enters the root pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q[0] <= 1'b0;
    else if (en) sq_v_q[0] <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0]     <= s4_q;
      sq_s_q[0]   <= 64'(s4_sq_q[0]) + 64'(s4_sq_q[1]) + 64'(s4_sq_q[2]);
      sq_res_q[0] <= '0;
    end
  end

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'(1) << (62 - 2 * g);
    logic [63:0] t;
    assign t = sq_res_q[g] + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[g+1] <= 1'b0;
      else if (en) sq_v_q[g+1] <= sq_v_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[g+1] <= sq_q[g];
        if (sq_s_q[g] >= t) begin
          sq_s_q[g+1]   <= sq_s_q[g] - t;
          sq_res_q[g+1] <= (sq_res_q[g] >> 1) + Bit;
        end else begin
          sq_s_q[g+1]   <= sq_s_q[g];
          sq_res_q[g+1] <= sq_res_q[g] >> 1;
        end
      end
    end
  end

  // division pipe, one quotient bit per stage and three lanes
  logic              dv_v_q   [DivSteps+1];
  nrm_t              dv_q     [DivSteps+1];
  logic [RootW-1:0]  dv_r_q   [DivSteps+1];
  logic [2:0][NumW-1:0]  dv_rem_q [DivSteps+1];
  logic [2:0][QuotW-1:0] dv_quo_q [DivSteps+1];

  // dividend with half the root added for rounding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else if (en) dv_v_q[0] <= sq_v_q[SqrtSteps];
  end

  always_ff @(posedge clk_i) begin
    logic [RootW-1:0] r;
    if (en) begin
      r = sq_res_q[SqrtSteps][RootW-1:0];
      dv_q[0]   <= sq_q[SqrtSteps];
      dv_r_q[0] <= r;
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= NumW'({sq_q[SqrtSteps].m[i], 16'b0}) + NumW'(r[RootW-1:1]);
        dv_quo_q[0][i] <= '0;
      end
    end
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    localparam int unsigned Sh = DivSteps - 1 - g;
    logic [NumW-1:0] dsr;
    assign dsr = NumW'(dv_r_q[g]) << Sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[g+1] <= 1'b0;
      else if (en) dv_v_q[g+1] <= dv_v_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[g+1]   <= dv_q[g];
        dv_r_q[g+1] <= dv_r_q[g];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_q[g][i] >= dsr) begin
            dv_rem_q[g+1][i] <= dv_rem_q[g][i] - dsr;
            dv_quo_q[g+1][i] <= dv_quo_q[g][i] | (QuotW'(1) << Sh);
          end else begin
            dv_rem_q[g+1][i] <= dv_rem_q[g][i];
            dv_quo_q[g+1][i] <= dv_quo_q[g][i];
          end
        end
      end
    end
  end

  // primary up vector with optional acceleration term
  logic               pa_v_q;
  logic signed [31:0] pa_prim_q [3];
  logic [2:0][31:0]   pa_fr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pa_v_q <= 1'b0;
    else if (en) pa_v_q <= dv_v_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] u, pr;
    logic [63:0] ap;
    logic [64:0] sum;
    nrm_t        n;
    if (en) begin
      n = dv_q[DivSteps];
      pa_fr_q <= n.side.fr;
      for (int i = 0; i < 3; i++) begin
        u  = 32'(dv_quo_q[DivSteps][i]);
        u  = n.zero ? 32'd0 : (n.sgn[i] ? 32'(-u) : u);
        pr = center_q ? u : force_q[i];
        ap = n.side.prod[i];
        sum = {{33{pr[31]}}, pr} + {{17{ap[63]}}, ap[63:16]};
        pa_prim_q[i] <= (accen_q && (gain_q != '0)) ? sat32(sum) : pr;
      end
    end
  end

  // first cross product: partial products
  logic               x1_v_q;
  logic signed [63:0] x1_a_q [3], x1_b_q [3];
  logic [2:0][31:0]   x1_fr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) x1_v_q <= 1'b0;
    else if (en) x1_v_q <= pa_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_fr_q <= pa_fr_q;
      for (int i = 0; i < 3; i++) begin
        x1_a_q[i] <= $signed(pa_fr_q[(i+1)%3]) * pa_prim_q[(i+2)%3];
        x1_b_q[i] <= $signed(pa_fr_q[(i+2)%3]) * pa_prim_q[(i+1)%3];
      end
    end
  end

  // first cross product: right vector
  logic             x2_v_q;
  logic [2:0][63:0] x2_right_q;
  logic [2:0][31:0] x2_fr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) x2_v_q <= 1'b0;
    else if (en) x2_v_q <= x1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_fr_q <= x1_fr_q;
      for (int i = 0; i < 3; i++) begin
        x2_right_q[i] <= x1_a_q[i] - x1_b_q[i];
      end
    end
  end

  // second cross product: right split into high and low words
  logic               y1_v_q;
  logic signed [63:0] y1_ah_q [3], y1_bh_q [3];
  logic signed [64:0] y1_al_q [3], y1_bl_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) y1_v_q <= 1'b0;
    else if (en) y1_v_q <= x2_v_q;
  end

  always_ff @(posedge clk_i) begin
    logic [63:0] ra, rb;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ra = x2_right_q[(i+1)%3];
        rb = x2_right_q[(i+2)%3];
        y1_ah_q[i] <= $signed(ra[63:32]) * $signed(x2_fr_q[(i+2)%3]);
        y1_al_q[i] <= $signed({1'b0, ra[31:0]}) * $signed(x2_fr_q[(i+2)%3]);
        y1_bh_q[i] <= $signed(rb[63:32]) * $signed(x2_fr_q[(i+1)%3]);
        y1_bl_q[i] <= $signed({1'b0, rb[31:0]}) * $signed(x2_fr_q[(i+1)%3]);
      end
    end
  end

  // second cross product: recombine the partial products
  logic        y2_v_q;
  logic [96:0] y2_a_q [3], y2_b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) y2_v_q <= 1'b0;
    else if (en) y2_v_q <= y1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        y2_a_q[i] <= {y1_ah_q[i][63], y1_ah_q[i], 32'b0}
                   + {{32{y1_al_q[i][64]}}, y1_al_q[i]};
        y2_b_q[i] <= {y1_bh_q[i][63], y1_bh_q[i], 32'b0}
                   + {{32{y1_bl_q[i][64]}}, y1_bl_q[i]};
      end
    end
  end

  // difference, floor shift by 32 and saturation
  logic        y3_v_q;
  logic [31:0] y3_up_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) y3_v_q <= 1'b0;
    else if (en) y3_v_q <= y2_v_q;
  end

  always_ff @(posedge clk_i) begin
    logic [96:0] v;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v = y2_a_q[i] - y2_b_q[i];
        y3_up_q[i] <= sat32(v[96:32]);
      end
    end
  end

  // two entry output buffer
  logic [31:0] ob0_q [3], ob1_q [3];
  logic        push, pop;

  assign push        = en && y3_v_q;
  assign out_valid_o = (ob_cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign up_x_o      = ob0_q[0];
  assign up_y_o      = ob0_q[1];
  assign up_z_o      = ob0_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ob_cnt_q <= 2'd0;
    else ob_cnt_q <= ob_cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push && ((ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && pop))) begin
      ob0_q <= y3_up_q;
    end else if (pop && (ob_cnt_q == 2'd2)) begin
      ob0_q <= ob1_q;
    end else if (push && (ob_cnt_q == 2'd1)) begin
      ob1_q <= y3_up_q;
    end
  end

`ifndef SYNTHESIS
  // buffer fill stays within two entries
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt_q != 2'd3) else $error("output buffer count out of range");

  // a stalled pipe keeps its last stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(y3_v_q)) else $error("pipe moved while stalled");

  // no push into a full buffer
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(y3_v_q && (ob_cnt_q == 2'd2) && en)) else $error("output buffer overflow");

  // a zero difference vector leaves zero magnitudes after scaling
  a_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && s3_q.zero) |-> (s3_q.m == '0)) else $error("zero flag with nonzero magnitude");
`endif

endmodule

### test/tb_top.sv
// tb_top: self-checking testbench for gravity_up_vector_core
// depends on gup_pkg (register codes) and the core; directed table, then random phases
module tb_top;
  import gup_pkg::*;

  typedef logic [0:2][31:0] vec_t;

  typedef struct packed {
    vec_t        frc;
    logic        center;
    logic        accel_en;
    logic [31:0] gain;
  } cfg_t;

  typedef struct packed {
    vec_t pos;
    vec_t fr;
    vec_t ac;
  } item_t;

  typedef struct packed {
    cfg_t  c;
    item_t it;
    logic  typed;
    vec_t  up;
  } row_t;

  localparam logic [31:0] OneQ = 32'h0001_0000;
  localparam logic [31:0] MaxQ = 32'h7FFF_FFFF;
  localparam logic [31:0] MinQ = 32'h8000_0000;
  localparam int unsigned DrainCycles = 70;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [31:0] front_x = '0, front_y = '0, front_z = '0;
  logic [31:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] up_x, up_y, up_z;

  cfg_t cur;
  vec_t up_q[$];
  int   errors = 0;
  bit   calm = 1'b0;

  gravity_up_vector_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .front_x_i(front_x), .front_y_i(front_y), .front_z_i(front_z),
    .accel_x_i(accel_x), .accel_y_i(accel_y), .accel_z_i(accel_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .up_x_o(up_x), .up_y_o(up_y), .up_z_o(up_z)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // up vector predictor: primary vector, accel term, double cross product
  function automatic vec_t predict_up(input cfg_t c, input item_t it);
    logic signed [63:0]  d[3];
    logic signed [63:0]  prim[3];
    logic signed [63:0]  t;
    logic [63:0]         m[3];
    logic [63:0]         mx, s, r, b, q;
    logic signed [127:0] f[3], p[3], rt[3], v;
    vec_t                res;
    int                  j, k;
    for (int i = 0; i < 3; i++) begin
      d[i] = 64'($signed(it.pos[i])) - 64'($signed(c.frc[i]));
      prim[i] = 64'($signed(c.frc[i]));
    end
    // center mode: rounded unit vector from center to position
    if (c.center) begin
      mx = '0;
      for (int i = 0; i < 3; i++) begin
        m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        for (int i = 0; i < 3; i++) prim[i] = '0;
      end else begin
        while (mx >= 64'(1) << 30) begin
          mx = mx >> 1;
          for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < 64'(1) << 29) begin
          mx = mx << 1;
          for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = '0;
        b = 64'(1) << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
          if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
          b = b >> 2;
        end
        for (int i = 0; i < 3; i++) begin
          q = ((m[i] << 16) + (r >> 1)) / r;
          prim[i] = d[i] < 0 ? -$signed(q) : $signed(q);
        end
      end
    end
    // scaled acceleration, saturated sum
    if (c.accel_en && c.gain != 0) begin
      for (int i = 0; i < 3; i++) begin
        t = 64'($signed(it.ac[i])) * 64'($signed(c.gain));
        t = prim[i] + (t >>> 16);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        else if (t < -64'sd2147483648) t = -64'sd2147483648;
        prim[i] = t;
      end
    end
    for (int i = 0; i < 3; i++) begin
      f[i] = 128'($signed(it.fr[i]));
      p[i] = 128'(prim[i]);
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      rt[i] = f[j] * p[k] - f[k] * p[j];
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      v = (rt[j] * f[k] - rt[k] * f[j]) >>> 32;
      if (v > 128'sd2147483647) res[i] = MaxQ;
      else if (v < -128'sd2147483648) res[i] = MinQ;
      else res[i] = v[31:0];
    end
    return res;
  endfunction

  // mix of full range, small, extreme and unit values
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 9))
      4, 5: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
      6: return MaxQ;
      7: return MinQ;
      8: return '0;
      9: return $urandom_range(0, 1) ? OneQ : -OneQ;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t row(input cfg_t c, input vec_t pos, input vec_t fr, input vec_t ac,
                               input logic typed, input vec_t up);
    return '{c: c, it: '{pos: pos, fr: fr, ac: ac}, typed: typed, up: up};
  endfunction

  // wait until every expected result is back and the pipe has emptied
  task automatic drain();
    in_valid <= 1'b0;
    while (up_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // apb write: setup, then access
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_cfg(input cfg_t c);
    drain();
    reg_write(RegForceX, c.frc[0]);
    reg_write(RegForceY, c.frc[1]);
    reg_write(RegForceZ, c.frc[2]);
    reg_write(RegCenter, {31'd0, c.center});
    reg_write(RegAccelEn, {31'd0, c.accel_en});
    reg_write(RegAccelGain, c.gain);
    cur = c;
  endtask

  // one input transaction; expectation queued when accepted
  task automatic send_item(input item_t it, input logic typed, input vec_t up);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {pos_x, pos_y, pos_z} <= it.pos;
    {front_x, front_y, front_z} <= it.fr;
    {accel_x, accel_y, accel_z} <= it.ac;
    do @(posedge clk); while (!in_ready);
    up_q.push_back(typed ? up : predict_up(cur, it));
  endtask

  // output side: random stalls and comparison
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (up_q.size() == 0) begin
          $display("%0t: result with none expected: %h %h %h", $time, up_x, up_y, up_z);
          errors++;
        end else begin
          automatic vec_t e = up_q.pop_front();
          automatic vec_t a = {up_x, up_y, up_z};
          for (int i = 0; i < 3; i++) begin
            if (e[i] !== a[i]) begin
              $display("%0t: up[%0d] expected %h actual %h", $time, i, e[i], a[i]);
              errors++;
            end
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 7);
    end
  end

  // stimulus
  initial begin
    row_t  tbl[15];
    cfg_t  c_rst, c_cen, c_acc0, c_acc1, c_big, c_neg, c_gmax, c_gmin;
    cfg_t  c;
    item_t it;
    c_rst  = '{frc: {32'd0, OneQ, 32'd0}, center: 1'b0, accel_en: 1'b0, gain: '0};
    c_cen  = '{frc: {32'd0, 32'd0, 32'd0}, center: 1'b1, accel_en: 1'b0, gain: '0};
    c_acc0 = '{frc: {32'd0, OneQ, 32'd0}, center: 1'b0, accel_en: 1'b1, gain: '0};
    c_acc1 = '{frc: {32'd0, 32'd0, 32'd0}, center: 1'b0, accel_en: 1'b1, gain: OneQ};
    c_big  = '{frc: {32'd0, MaxQ, 32'd0}, center: 1'b0, accel_en: 1'b0, gain: '0};
    c_neg  = '{frc: {MinQ, MinQ, MinQ}, center: 1'b1, accel_en: 1'b0, gain: '0};
    c_gmax = '{frc: {MaxQ, MaxQ, MaxQ}, center: 1'b0, accel_en: 1'b1, gain: MaxQ};
    c_gmin = '{frc: {MinQ, 32'd0, MaxQ}, center: 1'b1, accel_en: 1'b1, gain: MinQ};

    // directed table: settings, position, front, accel, typed result
    tbl[0]  = row(c_rst, {3{32'd0}}, {OneQ, 32'd0, 32'd0}, {3{32'd0}}, 1, {32'd0, OneQ, 32'd0});
    tbl[1]  = row(c_rst, {3{MaxQ}}, {3{32'd0}}, {3{MaxQ}}, 1, {3{32'd0}});
    tbl[2]  = row(c_rst, {3{MinQ}}, {32'd0, OneQ, 32'd0}, {3{MinQ}}, 1, {3{32'd0}});
    tbl[3]  = row(c_rst, {3{MaxQ}}, {MaxQ, MinQ, OneQ}, {3{MaxQ}}, 0, '0);
    tbl[4]  = row(c_cen, {3{32'd0}}, {OneQ, 32'd0, 32'd0}, {3{32'd0}}, 1, {3{32'd0}});
    tbl[5]  = row(c_cen, {5 * OneQ, 32'd0, 32'd0}, {32'd0, 32'd0, OneQ}, {3{32'd0}}, 1,
                  {OneQ, 32'd0, 32'd0});
    tbl[6]  = row(c_cen, {MaxQ, MinQ, 32'd7}, {OneQ, OneQ, 32'd0}, {3{32'd0}}, 0, '0);
    tbl[7]  = row(c_neg, {3{MaxQ}}, {32'd3, OneQ, MinQ}, {3{32'd0}}, 0, '0);
    tbl[8]  = row(c_neg, {3{MinQ}}, {OneQ, 32'd0, 32'd0}, {3{MaxQ}}, 1, {3{32'd0}});
    tbl[9]  = row(c_acc0, {3{32'd0}}, {OneQ, 32'd0, 32'd0}, {3{MaxQ}}, 1, {32'd0, OneQ, 32'd0});
    tbl[10] = row(c_acc1, {3{32'd0}}, {OneQ, 32'd0, 32'd0}, {32'd0, 2 * OneQ, 32'd0}, 1,
                  {32'd0, 2 * OneQ, 32'd0});
    tbl[11] = row(c_gmax, {3{32'd0}}, {OneQ, MaxQ, MinQ}, {3{MaxQ}}, 0, '0);
    tbl[12] = row(c_gmin, {MinQ, 32'd0, MaxQ}, {MaxQ, 32'd1, OneQ}, {3{MinQ}}, 0, '0);
    tbl[13] = row(c_big, {3{32'd0}}, {MaxQ, 32'd0, 32'd0}, {3{32'd0}}, 1, {32'd0, MaxQ, 32'd0});
    tbl[14] = row('{frc: {32'd0, MinQ, 32'd0}, center: 1'b0, accel_en: 1'b0, gain: '0},
                  {3{32'd0}}, {MaxQ, 32'd0, 32'd0}, {3{32'd0}}, 1, {32'd0, MinQ, 32'd0});

    cur = c_rst;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (tbl[n]) begin
      if (tbl[n].c != cur) load_cfg(tbl[n].c);
      send_item(tbl[n].it, tbl[n].typed, tbl[n].up);
    end

    // random phases over center mode, accel enable, force and gain settings
    for (int ph = 0; ph < 8; ph++) begin
      c.center = ph[0];
      c.accel_en = ph[1];
      for (int i = 0; i < 3; i++) c.frc[i] = (ph == 2) ? MaxQ : (ph == 4) ? MinQ : rand_q();
      c.gain = (ph == 3) ? 32'd0 : (ph == 5) ? MaxQ : (ph == 7) ? MinQ : rand_q();
      load_cfg(c);
      calm = (ph == 3);
      for (int n = 0; n < 215; n++) begin
        for (int i = 0; i < 3; i++) begin
          it.pos[i] = rand_q();
          it.fr[i] = rand_q();
          it.ac[i] = rand_q();
        end
        // degenerate center: position on the center point
        if ($urandom_range(0, 9) == 0) it.pos = c.frc;
        send_item(it, 1'b0, '0);
      end
      calm = 1'b0;
    end
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
